[rtl/mwsm_pkg.sv]
// Shared types, widths and constants for the mecanum wheel speed mixer.
// Used by every module of the block; depends on nothing.
`default_nettype none

package mwsm_pkg;

    localparam int SPEED_W    = 16;
    localparam int OFFSET_W   = 11;
    localparam int LEVER_W    = 14;
    localparam int ROT_PROD_W = SPEED_W + LEVER_W;
    localparam int ROT_K_W    = 20;
    localparam int ROT_FULL_W = ROT_PROD_W + ROT_K_W;
    localparam int FRAC_W     = 24;
    localparam int GAIN_W     = 24;
    localparam int SUM_W      = SPEED_W + 2;
    localparam int RPM_PROD_W = SPEED_W + GAIN_W + 1;
    localparam int MAG_W      = 15;
    localparam int NUM_W      = 2 * MAG_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int WHEELS     = 4;

    localparam int WHEEL_FR = 0;
    localparam int WHEEL_FL = 1;
    localparam int WHEEL_BL = 2;
    localparam int WHEEL_BR = 3;

    localparam logic signed [ROT_K_W-1:0] RAD_PER_DEG_Q24 = 20'sd292818;

    localparam int FRONT_STAGES = 8;
    localparam int DIV_STAGES   = MAG_W;
    localparam int LATENCY      = FRONT_STAGES + 1 + 2 + DIV_STAGES + 1;

    localparam int MAX_FORWARD_SPEED_DEF  = 3300;
    localparam int MAX_LATERAL_SPEED_DEF  = 3300;
    localparam int MAX_ROTATION_SPEED_DEF = 300;
    localparam int QUEUE_DEPTH_DEF        = 16;

    localparam logic [OFFSET_W-1:0] HALF_SPAN_RST = 11'd500;
    localparam logic [GAIN_W-1:0]   RPM_GAIN_RST  = 24'd110000;
    localparam logic [MAG_W-1:0]    MAX_RPM_RST   = 15'd8500;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HALF_SPAN     = 3'd0,
        REG_GIMBAL_X      = 3'd1,
        REG_GIMBAL_Y      = 3'd2,
        REG_DODGE_X       = 3'd3,
        REG_ROTATE_GIMBAL = 3'd4,
        REG_RPM_GAIN      = 3'd5,
        REG_MAX_RPM       = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic [OFFSET_W-1:0] half_span;
        logic [OFFSET_W-1:0] gimbal_x;
        logic [OFFSET_W-1:0] gimbal_y;
        logic [OFFSET_W-1:0] dodge_x;
        logic                rotate_gimbal;
        logic [GAIN_W-1:0]   rpm_gain;
        logic [MAG_W-1:0]    max_rpm;
    } cfg_t;

    typedef struct packed {
        logic [WHEELS-1:0][MAG_W-1:0] mag;
        logic [WHEELS-1:0]            neg;
        logic [MAG_W-1:0]             peak;
        logic                         scale;
    } q_entry_t;

endpackage

`default_nettype wire

[rtl/mwsm_front.sv]
// Front pipeline: clamp, rotation lever, wheel mix, rpm conversion and peak check.
// Depends on mwsm_pkg; feeds classified items to mwsm_queue.
`default_nettype none

module mwsm_front
    import mwsm_pkg::*;
#(
    parameter int MAX_FORWARD_SPEED  = MAX_FORWARD_SPEED_DEF,
    parameter int MAX_LATERAL_SPEED  = MAX_LATERAL_SPEED_DEF,
    parameter int MAX_ROTATION_SPEED = MAX_ROTATION_SPEED_DEF
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    input  wire logic signed [SPEED_W-1:0] speed_forward,
    input  wire logic signed [SPEED_W-1:0] speed_lateral,
    input  wire logic signed [SPEED_W-1:0] speed_rotation,
    input  wire logic                      evasive_mode,
    input  wire cfg_t                      cfg,
    output logic                           out_valid,
    output q_entry_t                       out_entry
);

    localparam int SAT_HI = 2 ** (SPEED_W - 1) - 1;
    localparam int SAT_LO = -(2 ** (SPEED_W - 1));
    localparam int ROT_SH_W = ROT_FULL_W - FRAC_W;

    function automatic logic signed [SPEED_W-1:0] clamp_speed(
        input logic signed [SPEED_W-1:0] v,
        input logic signed [SPEED_W-1:0] lim
    );
        logic signed [SPEED_W-1:0] r;
        r = v;
        if (v > lim)
        begin
            r = lim;
        end
        else if (v < -lim)
        begin
            r = -lim;
        end
        return r;
    endfunction

    function automatic logic signed [SPEED_W-1:0] sat_rot(
        input logic signed [ROT_SH_W-1:0] v
    );
        logic signed [SPEED_W-1:0] r;
        r = SPEED_W'(v);
        if (v > SAT_HI)
        begin
            r = SPEED_W'(SAT_HI);
        end
        else if (v < SAT_LO)
        begin
            r = SPEED_W'(SAT_LO);
        end
        return r;
    endfunction

    function automatic logic signed [SPEED_W-1:0] sat_sum(
        input logic signed [SUM_W-1:0] v
    );
        logic signed [SPEED_W-1:0] r;
        r = SPEED_W'(v);
        if (v > SAT_HI)
        begin
            r = SPEED_W'(SAT_HI);
        end
        else if (v < SAT_LO)
        begin
            r = SPEED_W'(SAT_LO);
        end
        return r;
    endfunction

    logic [FRONT_STAGES-1:0] vld_reg;

    logic signed [SPEED_W-1:0]    vx_reg [4];
    logic signed [SPEED_W-1:0]    vy_reg [4];
    logic signed [SPEED_W-1:0]    vw1_reg;
    logic signed [LEVER_W-1:0]    lever1_reg [WHEELS];
    logic signed [ROT_PROD_W-1:0] p2_reg [WHEELS];
    logic signed [ROT_FULL_W-1:0] prod3_reg [WHEELS];
    logic signed [SPEED_W-1:0]    r4_reg [WHEELS];
    logic signed [SPEED_W-1:0]    sum5_reg [WHEELS];
    logic signed [RPM_PROD_W-1:0] g6_reg [WHEELS];
    logic [WHEELS-1:0][MAG_W-1:0] mag7_reg;
    logic [WHEELS-1:0]            neg7_reg;
    q_entry_t                     entry8_reg;

    logic signed [SPEED_W-1:0]    vx_next;
    logic signed [SPEED_W-1:0]    vy_next;
    logic signed [SPEED_W-1:0]    vw_next;
    logic signed [LEVER_W-1:0]    h_s;
    logic signed [LEVER_W-1:0]    cx_s;
    logic signed [LEVER_W-1:0]    cy_s;
    logic signed [LEVER_W-1:0]    lever_next [WHEELS];
    logic signed [ROT_FULL_W-1:0] rot_adj [WHEELS];
    logic signed [SUM_W-1:0]      vx_e;
    logic signed [SUM_W-1:0]      vy_e;
    logic signed [SUM_W-1:0]      r_e [WHEELS];
    logic signed [SUM_W-1:0]      sum_next [WHEELS];
    logic signed [RPM_PROD_W-1:0] g_adj [WHEELS];
    logic signed [SPEED_W-1:0]    rpm_next [WHEELS];
    logic [SPEED_W-1:0]           mag_full [WHEELS];
    logic [MAG_W-1:0]             peak_a;
    logic [MAG_W-1:0]             peak_b;
    logic [MAG_W-1:0]             peak_next;

    always_comb
    begin
        vx_next = clamp_speed(speed_forward, $signed(SPEED_W'(MAX_FORWARD_SPEED)));
        vy_next = clamp_speed(speed_lateral, $signed(SPEED_W'(MAX_LATERAL_SPEED)));
        vw_next = clamp_speed(speed_rotation, $signed(SPEED_W'(MAX_ROTATION_SPEED)));
        h_s  = $signed(LEVER_W'(cfg.half_span));
        cx_s = '0;
        cy_s = '0;
        if (evasive_mode)
        begin
            cx_s = LEVER_W'($signed(cfg.dodge_x));
        end
        else if (cfg.rotate_gimbal)
        begin
            cx_s = LEVER_W'($signed(cfg.gimbal_x));
            cy_s = LEVER_W'($signed(cfg.gimbal_y));
        end
        lever_next[WHEEL_FR] = h_s - cx_s + cy_s;
        lever_next[WHEEL_FL] = h_s - cx_s - cy_s;
        lever_next[WHEEL_BL] = h_s + cx_s - cy_s;
        lever_next[WHEEL_BR] = h_s + cx_s + cy_s;
    end

    // truncate toward zero: bias negative products by one LSB short of the shift
    always_comb
    begin
        vx_e = SUM_W'(vx_reg[3]);
        vy_e = SUM_W'(vy_reg[3]);
        for (int i = 0; i < WHEELS; i++)
        begin
            rot_adj[i] = prod3_reg[i] + $signed({{ROT_SH_W{1'b0}},
                                                 {FRAC_W{prod3_reg[i][ROT_FULL_W-1]}}});
            r_e[i] = SUM_W'(r4_reg[i]);
            g_adj[i] = g6_reg[i] + $signed({{(RPM_PROD_W-FRAC_W){1'b0}},
                                             {FRAC_W{g6_reg[i][RPM_PROD_W-1]}}});
            rpm_next[i] = $signed(g_adj[i][FRAC_W+SPEED_W-1:FRAC_W]);
            mag_full[i] = rpm_next[i][SPEED_W-1] ? -rpm_next[i] : rpm_next[i];
        end
        sum_next[WHEEL_FR] = -vx_e - vy_e - r_e[WHEEL_FR];
        sum_next[WHEEL_FL] =  vx_e - vy_e - r_e[WHEEL_FL];
        sum_next[WHEEL_BL] =  vx_e + vy_e - r_e[WHEEL_BL];
        sum_next[WHEEL_BR] = -vx_e + vy_e - r_e[WHEEL_BR];
    end

    always_comb
    begin
        peak_a    = (mag7_reg[0] > mag7_reg[1]) ? mag7_reg[0] : mag7_reg[1];
        peak_b    = (mag7_reg[2] > mag7_reg[3]) ? mag7_reg[2] : mag7_reg[3];
        peak_next = (peak_a > peak_b) ? peak_a : peak_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[FRONT_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        vx_reg[0] <= vx_next;
        vy_reg[0] <= vy_next;
        for (int k = 1; k < 4; k++)
        begin
            vx_reg[k] <= vx_reg[k-1];
            vy_reg[k] <= vy_reg[k-1];
        end
        vw1_reg <= vw_next;
        for (int i = 0; i < WHEELS; i++)
        begin
            lever1_reg[i] <= lever_next[i];
            p2_reg[i]     <= vw1_reg * lever1_reg[i];
            prod3_reg[i]  <= p2_reg[i] * RAD_PER_DEG_Q24;
            r4_reg[i]     <= sat_rot($signed(rot_adj[i][ROT_FULL_W-1:FRAC_W]));
            sum5_reg[i]   <= sat_sum(sum_next[i]);
            g6_reg[i]     <= sum5_reg[i] * $signed({1'b0, cfg.rpm_gain});
            neg7_reg[i]   <= rpm_next[i][SPEED_W-1];
            mag7_reg[i]   <= mag_full[i][MAG_W-1:0];
        end
        entry8_reg.mag   <= mag7_reg;
        entry8_reg.neg   <= neg7_reg;
        entry8_reg.peak  <= peak_next;
        entry8_reg.scale <= (peak_next > cfg.max_rpm);
    end

    assign out_valid = vld_reg[FRONT_STAGES-1];
    assign out_entry = entry8_reg;

endmodule

`default_nettype wire

[rtl/mwsm_queue.sv]
// Short item queue between the front and back pipelines.
// Depends on mwsm_pkg for the entry type; occupancy is bounded by the top-level credits.
`default_nettype none

module mwsm_queue
    import mwsm_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire q_entry_t push_entry,
    input  wire logic     pop,
    output q_entry_t      pop_entry,
    output logic          empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    q_entry_t           mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assign pop_entry = mem_reg[rd_ptr_reg];
    assign empty     = (count_reg == '0);

endmodule

`default_nettype wire

[rtl/mwsm_back.sv]
// Back pipeline: proportional scaling by a one-bit-per-stage restoring divider.
// Depends on mwsm_pkg; takes items from mwsm_queue and drives the result ports.
`default_nettype none

module mwsm_back
    import mwsm_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    input  wire q_entry_t               in_entry,
    input  wire logic [MAG_W-1:0]       max_rpm,
    output logic                        done,
    output logic [WHEELS-1:0][SPEED_W-1:0] rpm,
    output logic                        scaled_down
);

    typedef struct packed {
        logic                         scale;
        logic [WHEELS-1:0]            neg;
        logic [MAG_W-1:0]             peak;
        logic [WHEELS-1:0][NUM_W-1:0] rem;
        logic [WHEELS-1:0][MAG_W-1:0] quo;
    } div_t;

    logic [DIV_STAGES+1:0]          vld_reg;
    logic                           done_reg;
    q_entry_t                       ent0_reg;
    div_t                           div_reg [DIV_STAGES+1];
    div_t                           div_next [DIV_STAGES+1];
    logic [WHEELS-1:0][SPEED_W-1:0] rpm_reg;
    logic [WHEELS-1:0][SPEED_W-1:0] rpm_next;
    logic                           scaled_reg;
    logic [NUM_W-1:0]               trial;

    // stage j settles quotient bit MAG_W-j; unscaled items ride through in quo
    always_comb
    begin
        trial = '0;
        div_next[0].scale = ent0_reg.scale;
        div_next[0].neg   = ent0_reg.neg;
        div_next[0].peak  = ent0_reg.peak;
        for (int i = 0; i < WHEELS; i++)
        begin
            div_next[0].rem[i] = ent0_reg.scale ? ent0_reg.mag[i] * max_rpm : '0;
            div_next[0].quo[i] = ent0_reg.scale ? '0 : ent0_reg.mag[i];
        end
        for (int j = 1; j <= DIV_STAGES; j++)
        begin
            div_next[j] = div_reg[j-1];
            trial = NUM_W'(div_reg[j-1].peak) << (MAG_W - j);
            for (int i = 0; i < WHEELS; i++)
            begin
                if (div_reg[j-1].scale && (div_reg[j-1].rem[i] >= trial))
                begin
                    div_next[j].rem[i]          = div_reg[j-1].rem[i] - trial;
                    div_next[j].quo[i][MAG_W-j] = 1'b1;
                end
            end
        end
        for (int i = 0; i < WHEELS; i++)
        begin
            rpm_next[i] = div_reg[DIV_STAGES].neg[i]
                        ? -SPEED_W'(div_reg[DIV_STAGES].quo[i])
                        : SPEED_W'(div_reg[DIV_STAGES].quo[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg  <= {vld_reg[DIV_STAGES:0], in_valid};
            done_reg <= vld_reg[DIV_STAGES+1];
        end
    end

    always_ff @(posedge clk)
    begin
        ent0_reg   <= in_entry;
        div_reg    <= div_next;
        rpm_reg    <= rpm_next;
        scaled_reg <= div_reg[DIV_STAGES].scale;
    end

    assign done        = done_reg;
    assign rpm         = rpm_reg;
    assign scaled_down = scaled_reg;

endmodule

`default_nettype wire

[rtl/mecanum_wheel_speed_mixer_core.sv]
// Mecanum wheel speed mixer: config registers, item credits, front/queue/back.
// Throughput: one item per cycle while busy is low; busy rises only with QUEUE_DEPTH items in flight,
// set by the credit count over front pipeline and queue.
// Reset: rst_n asynchronous, active low; clears all valids and credits and
// loads the configuration registers with their reset values.
`default_nettype none

module mecanum_wheel_speed_mixer_core
    import mwsm_pkg::*;
#(
    parameter int MAX_FORWARD_SPEED  = MAX_FORWARD_SPEED_DEF,
    parameter int MAX_LATERAL_SPEED  = MAX_LATERAL_SPEED_DEF,
    parameter int MAX_ROTATION_SPEED = MAX_ROTATION_SPEED_DEF,
    parameter int QUEUE_DEPTH        = QUEUE_DEPTH_DEF
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic signed [SPEED_W-1:0] speed_forward,
    input  wire logic signed [SPEED_W-1:0] speed_lateral,
    input  wire logic signed [SPEED_W-1:0] speed_rotation,
    input  wire logic                      evasive_mode,
    output logic                           done,
    output logic signed [SPEED_W-1:0]      rpm_front_right,
    output logic signed [SPEED_W-1:0]      rpm_front_left,
    output logic signed [SPEED_W-1:0]      rpm_back_left,
    output logic signed [SPEED_W-1:0]      rpm_back_right,
    output logic                           scaled_down,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [CFG_DATA_W-1:0]     cfg_data
);

    localparam int CREDIT_W = $clog2(QUEUE_DEPTH + 1);

    cfg_t                           cfg_reg;
    logic [CREDIT_W-1:0]            credit_reg;
    logic [CREDIT_W-1:0]            credit_next;
    logic                           accept;
    logic                           cfg_wr;
    logic                           front_valid;
    q_entry_t                       front_entry;
    q_entry_t                       queue_entry;
    logic                           queue_empty;
    logic                           pop;
    logic [WHEELS-1:0][SPEED_W-1:0] rpm_w;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign busy      = (credit_reg == CREDIT_W'(QUEUE_DEPTH));
    assign accept    = start && !busy;
    assign pop       = !queue_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.half_span     <= HALF_SPAN_RST;
            cfg_reg.gimbal_x      <= '0;
            cfg_reg.gimbal_y      <= '0;
            cfg_reg.dodge_x       <= '0;
            cfg_reg.rotate_gimbal <= 1'b0;
            cfg_reg.rpm_gain      <= RPM_GAIN_RST;
            cfg_reg.max_rpm       <= MAX_RPM_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_index)
                REG_HALF_SPAN:     cfg_reg.half_span     <= cfg_data[OFFSET_W-1:0];
                REG_GIMBAL_X:      cfg_reg.gimbal_x      <= cfg_data[OFFSET_W-1:0];
                REG_GIMBAL_Y:      cfg_reg.gimbal_y      <= cfg_data[OFFSET_W-1:0];
                REG_DODGE_X:       cfg_reg.dodge_x       <= cfg_data[OFFSET_W-1:0];
                REG_ROTATE_GIMBAL: cfg_reg.rotate_gimbal <= cfg_data[0];
                REG_RPM_GAIN:      cfg_reg.rpm_gain      <= cfg_data[GAIN_W-1:0];
                REG_MAX_RPM:       cfg_reg.max_rpm       <= cfg_data[MAG_W-1:0];
                default:           cfg_reg               <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case ({accept, pop})
            2'b10:   credit_next = credit_reg + 1'b1;
            2'b01:   credit_next = credit_reg - 1'b1;
            default: credit_next = credit_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            credit_reg <= '0;
        end
        else
        begin
            credit_reg <= credit_next;
        end
    end

    mwsm_front #(
        .MAX_FORWARD_SPEED  (MAX_FORWARD_SPEED),
        .MAX_LATERAL_SPEED  (MAX_LATERAL_SPEED),
        .MAX_ROTATION_SPEED (MAX_ROTATION_SPEED)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (accept),
        .speed_forward  (speed_forward),
        .speed_lateral  (speed_lateral),
        .speed_rotation (speed_rotation),
        .evasive_mode   (evasive_mode),
        .cfg            (cfg_reg),
        .out_valid      (front_valid),
        .out_entry      (front_entry)
    );

    mwsm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (front_valid),
        .push_entry (front_entry),
        .pop        (pop),
        .pop_entry  (queue_entry),
        .empty      (queue_empty)
    );

    mwsm_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (pop),
        .in_entry    (queue_entry),
        .max_rpm     (cfg_reg.max_rpm),
        .done        (done),
        .rpm         (rpm_w),
        .scaled_down (scaled_down)
    );

    assign rpm_front_right = $signed(rpm_w[WHEEL_FR]);
    assign rpm_front_left  = $signed(rpm_w[WHEEL_FL]);
    assign rpm_back_left   = $signed(rpm_w[WHEEL_BL]);
    assign rpm_back_right  = $signed(rpm_w[WHEEL_BR]);

endmodule

`default_nettype wire

[rtl/mwsm_checker.sv]
// Port-level checks for the mecanum wheel speed mixer, bound to the top level.
// Depends on mwsm_pkg for the fixed latency.
`default_nettype none

module mwsm_checker
    import mwsm_pkg::*;
(
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      start,
    input wire logic                      busy,
    input wire logic signed [SPEED_W-1:0] speed_forward,
    input wire logic signed [SPEED_W-1:0] speed_lateral,
    input wire logic signed [SPEED_W-1:0] speed_rotation,
    input wire logic                      done,
    input wire logic signed [SPEED_W-1:0] rpm_front_right,
    input wire logic signed [SPEED_W-1:0] rpm_front_left,
    input wire logic signed [SPEED_W-1:0] rpm_back_left,
    input wire logic signed [SPEED_W-1:0] rpm_back_right,
    input wire logic                      scaled_down
);

    a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##LATENCY done)
        else $error("accepted item produced no result at the fixed latency");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result strobe without a matching accepted item");

    a_zero_command: assert property (@(posedge clk) disable iff (!rst_n)
        done && $past(start && !busy && speed_forward == 16'sd0
                      && speed_lateral == 16'sd0 && speed_rotation == 16'sd0, LATENCY)
        |-> rpm_front_right == 16'sd0 && rpm_front_left == 16'sd0
            && rpm_back_left == 16'sd0 && rpm_back_right == 16'sd0 && !scaled_down)
        else $error("zero velocity command produced nonzero wheel speeds");

    a_rpm_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> rpm_front_right != 16'sh8000 && rpm_front_left != 16'sh8000
                 && rpm_back_left != 16'sh8000 && rpm_back_right != 16'sh8000)
        else $error("wheel speed outside the symmetric range");

endmodule

bind mecanum_wheel_speed_mixer_core mwsm_checker u_mwsm_checker (.*);

`default_nettype wire
